// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, request codes, controller states and the result word
// layout of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int CELL_W     = 16;
	localparam int REQ_W      = 2;
	localparam int CHAR_W     = 8;
	localparam int COLOR_W    = 8;
	localparam int IDX_W      = 11;
	localparam int CURSOR_W   = 11;
	localparam int ROW_OUT_W  = 5;
	localparam int COL_OUT_W  = 7;

	localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

	localparam logic [CHAR_W-1:0]  CHAR_NEWLINE = 8'h0A;
	localparam logic [CHAR_W-1:0]  CHAR_SPACE   = 8'h20;
	localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'h0F;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCROLL,
		ST_FILL,
		ST_PUT,
		ST_RESULT
	} tcw_state_t;

	typedef struct packed {
		logic [CELL_W-1:0]    cell_value;
		logic [CURSOR_W-1:0]  cursor_cell;
		logic [ROW_OUT_W-1:0] cur_row;
		logic [COL_OUT_W-1:0] cur_col;
	} tcw_result_t;

endpackage

// ===== rtl/text_console_writer_unit.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text console engine: screen cell store with put, clear, scroll and read.
// ----------------------------------------------------------------------------
// Requests enter on the in_valid/in_ready channel (req_type, char_code,
// char_color, use_default, cell_index); every request returns one word on
// the out_valid/out_ready channel with the read cell, cursor and position. Write
// default_color (cfg_we/cfg_wdata) only while the unit is idle; unenforced.
//
// Request flow (R = ROWS):
//   put, read, unknown request : accepted, then held in the result state
//                                until its word enters the output register
//   put that scrolls           : copy of R-1 rows plus fill of the bottom
//                                row, one cell per cycle
//   clear                      : fill of every cell, one cell per cycle
// The single write port of the screen store sets the one-cell-per-cycle rate.
//
// After reset the store is filled with white spaces, one cell per cycle,
// with in_ready low; configuration writes are taken then. A result waits
// in the output register while the next request is already accepted and
// worked on; that request then holds until the register frees.
// ----------------------------------------------------------------------------
module text_console_writer_unit import tcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [COLOR_W-1:0]   cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [REQ_W-1:0]     req_type,
	input  logic [CHAR_W-1:0]    char_code,
	input  logic [COLOR_W-1:0]   char_color,
	input  logic                 use_default,
	input  logic [IDX_W-1:0]     cell_index,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CELL_W-1:0]    cell_value,
	output logic [CURSOR_W-1:0]  cursor_cell,
	output logic [ROW_OUT_W-1:0] cur_row,
	output logic [COL_OUT_W-1:0] cur_col
);

	localparam int CELLS  = ROWS * COLUMNS;
	localparam int ADDR_W = $clog2(CELLS);

	logic [COLOR_W-1:0] default_color_q;
	logic               out_valid_q;
	tcw_result_t        out_q;

	logic              mem_wr_en;
	logic [ADDR_W-1:0] mem_wr_addr;
	logic [CELL_W-1:0] mem_wr_data;
	logic              mem_rd_en;
	logic [ADDR_W-1:0] mem_rd_addr;
	logic [CELL_W-1:0] mem_rd_data;

	logic        res_valid;
	logic        res_take;
	tcw_result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_color_q <= COLOR_RESET;
		end else if (cfg_we) begin
			default_color_q <= cfg_wdata;
		end
	end

	tcw_screen_mem #(
		.DEPTH  (CELLS),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	tcw_ctrl #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.ADDR_W  (ADDR_W)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.default_color (default_color_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.char_code     (char_code),
		.char_color    (char_color),
		.use_default   (use_default),
		.cell_index    (cell_index),
		.mem_wr_en     (mem_wr_en),
		.mem_wr_addr   (mem_wr_addr),
		.mem_wr_data   (mem_wr_data),
		.mem_rd_en     (mem_rd_en),
		.mem_rd_addr   (mem_rd_addr),
		.mem_rd_data   (mem_rd_data),
		.res_valid     (res_valid),
		.res_take      (res_take),
		.res           (res)
	);

	// output word register
	assign res_take = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign cell_value  = out_q.cell_value;
	assign cursor_cell = out_q.cursor_cell;
	assign cur_row     = out_q.cur_row;
	assign cur_col     = out_q.cur_col;

endmodule

// ===== rtl/tcw_screen_mem.sv =====
// ----------------------------------------------------------------------------
// tcw_screen_mem
// Screen cell store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_screen_mem import tcw_pkg::*; #(
	parameter int DEPTH  = COLUMNS_DEF * ROWS_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [CELL_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [CELL_W-1:0] rd_data
);

	logic [CELL_W-1:0] mem [DEPTH];
	logic [CELL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// Request sequencer: write position, cursor, screen init/clear/scroll sweeps
// and single cell puts and reads against the screen store.
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF,
	parameter int ADDR_W  = $clog2(ROWS * COLUMNS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [COLOR_W-1:0] default_color,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [REQ_W-1:0]   req_type,
	input  logic [CHAR_W-1:0]  char_code,
	input  logic [COLOR_W-1:0] char_color,
	input  logic               use_default,
	input  logic [IDX_W-1:0]   cell_index,
	output logic               mem_wr_en,
	output logic [ADDR_W-1:0]  mem_wr_addr,
	output logic [CELL_W-1:0]  mem_wr_data,
	output logic               mem_rd_en,
	output logic [ADDR_W-1:0]  mem_rd_addr,
	input  logic [CELL_W-1:0]  mem_rd_data,
	output logic               res_valid,
	input  logic               res_take,
	output tcw_result_t        res
);

	localparam int CELLS      = ROWS * COLUMNS;
	localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;
	localparam int PTR_W      = $clog2(CELLS + 1);
	localparam int ROW_W      = $clog2(ROWS + 1);
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int COLP_W     = COL_W + 1;

	tcw_state_t state_q, state_d;
	logic [ADDR_W-1:0]  ptr_q, ptr_d;
	logic [ROW_W-1:0]   row_q, row_d;
	logic [COL_W-1:0]   col_q, col_d;
	logic [PTR_W-1:0]   cursor_q, cursor_d;
	logic [REQ_W-1:0]   req_q;
	logic [CHAR_W-1:0]  char_q;
	logic [COLOR_W-1:0] color_q;
	logic               range_q;

	logic               accept;
	logic               in_range;
	logic               row_past_end;
	logic               put_fire;
	logic [CHAR_W-1:0]  put_ch;
	logic [COLOR_W-1:0] put_color;
	logic [ADDR_W-1:0]  put_addr;
	logic [PTR_W-1:0]   put_cursor;
	logic [COLP_W-1:0]  col_inc;
	logic               col_wrap;
	logic [CELL_W-1:0]  fill_cell;

	assign in_ready     = (state_q == ST_IDLE);
	assign accept       = in_valid && in_ready;
	assign in_range     = 32'(cell_index) < 32'(CELLS);
	assign row_past_end = row_q >= ROW_W'(ROWS);
	assign fill_cell    = {default_color, CHAR_SPACE};

	assign put_fire = (accept && req_type == REQ_PUT && !row_past_end) ||
		(state_q == ST_PUT);
	assign put_ch    = (state_q == ST_IDLE) ? char_code : char_q;
	assign put_color = (state_q == ST_IDLE) ?
		(use_default ? default_color : char_color) : color_q;
	assign put_addr   = ADDR_W'(32'(row_q) * 32'(COLUMNS) + 32'(col_q));
	assign put_cursor = PTR_W'(32'(put_addr) + 32'd1);
	assign col_inc    = COLP_W'(col_q) + COLP_W'(1);
	assign col_wrap   = col_inc == COLP_W'(COLUMNS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			ptr_q    <= '0;
			row_q    <= '0;
			col_q    <= '0;
			cursor_q <= '0;
		end else begin
			state_q  <= state_d;
			ptr_q    <= ptr_d;
			row_q    <= row_d;
			col_q    <= col_d;
			cursor_q <= cursor_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req_type;
			char_q  <= char_code;
			color_q <= use_default ? default_color : char_color;
			range_q <= in_range;
		end
	end

	always_comb begin
		state_d     = state_q;
		ptr_d       = ptr_q;
		row_d       = row_q;
		col_d       = col_q;
		cursor_d    = cursor_q;
		mem_wr_en   = 1'b0;
		mem_wr_addr = ptr_q;
		mem_wr_data = fill_cell;
		mem_rd_en   = 1'b0;
		mem_rd_addr = ptr_q + ADDR_W'(COLUMNS);
		res_valid   = 1'b0;

		unique case (state_q)
			ST_INIT: begin
				mem_wr_en   = 1'b1;
				mem_wr_data = {COLOR_RESET, CHAR_SPACE};
				if (ptr_q == ADDR_W'(CELLS - 1)) begin
					ptr_d   = '0;
					state_d = ST_IDLE;
				end else begin
					ptr_d = ptr_q + ADDR_W'(1);
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (req_type)
						REQ_PUT: begin
							ptr_d   = '0;
							state_d = row_past_end ? ST_SCROLL : ST_RESULT;
						end
						REQ_CLEAR: begin
							ptr_d    = '0;
							cursor_d = '0;
							state_d  = ST_FILL;
						end
						REQ_READ: begin
							mem_rd_en   = in_range;
							mem_rd_addr = ADDR_W'(cell_index);
							state_d     = ST_RESULT;
						end
						default: begin
							state_d = ST_RESULT;
						end
					endcase
				end
			end
			ST_SCROLL: begin
				// read one row below, write the word read last cycle
				mem_rd_en   = ptr_q < ADDR_W'(COPY_CELLS);
				mem_wr_en   = ptr_q != '0;
				mem_wr_addr = ptr_q - ADDR_W'(1);
				mem_wr_data = mem_rd_data;
				if (ptr_q == ADDR_W'(COPY_CELLS)) begin
					state_d = ST_FILL;
				end else begin
					ptr_d = ptr_q + ADDR_W'(1);
				end
			end
			ST_FILL: begin
				mem_wr_en = 1'b1;
				if (ptr_q == ADDR_W'(CELLS - 1)) begin
					ptr_d = '0;
					if (req_q == REQ_PUT) begin
						row_d   = ROW_W'(ROWS - 1);
						state_d = ST_PUT;
					end else begin
						state_d = ST_RESULT;
					end
				end else begin
					ptr_d = ptr_q + ADDR_W'(1);
				end
			end
			ST_PUT: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase

		if (put_fire) begin
			if (put_ch == CHAR_NEWLINE) begin
				col_d = '0;
				row_d = row_q + ROW_W'(1);
			end else begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = put_addr;
				mem_wr_data = {put_color, put_ch};
				cursor_d    = put_cursor;
				if (col_wrap) begin
					col_d = '0;
					row_d = row_q + ROW_W'(1);
				end else begin
					col_d = col_inc[COL_W-1:0];
				end
			end
		end
	end

	assign res.cell_value  = (req_q == REQ_READ && range_q) ? mem_rd_data : '0;
	assign res.cursor_cell = CURSOR_W'(cursor_q);
	assign res.cur_row     = ROW_OUT_W'(row_q);
	assign res.cur_col     = COL_OUT_W'(col_q);

	// same-entry overlap never happens
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en && mem_rd_en |-> mem_wr_addr != mem_rd_addr)
		else $error("read and write hit the same cell");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= ROW_W'(ROWS) && 32'(col_q) < 32'(COLUMNS))
		else $error("write position out of range");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cursor_q) <= 32'(CELLS))
		else $error("cursor out of range");

	a_fast_put: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req_type == REQ_PUT && !row_past_end |=> state_q == ST_RESULT)
		else $error("plain put did not finish in one cycle");

	a_scroll_to_put: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PUT |-> row_q == ROW_W'(ROWS - 1))
		else $error("put after scroll not on bottom row");

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for text_console_writer_unit. A queue-fed valid/ready
// driver offers directed and random console requests (puts, newlines, long
// lines that wrap, scrolls, clears, reads and unknown codes) under several
// gap and stall mixes and default colors. A screen model predicts every
// returned word and a monitor checks it field by field.
// ----------------------------------------------------------------------------
module testbench;
	import tcw_pkg::*;

	localparam int SCREEN_COLS   = COLUMNS_DEF;
	localparam int SCREEN_ROWS   = ROWS_DEF;
	localparam int SCREEN_CELLS  = SCREEN_COLS * SCREEN_ROWS;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_WORDS   = 200;
	localparam int LONG_HOLD     = 300;
	localparam int QUIET_LIMIT   = 20000;
	localparam int DRAIN_CYCLES  = 10;

	localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [REQ_W-1:0]   req;
		logic [CHAR_W-1:0]  ch;
		logic [COLOR_W-1:0] color;
		logic               use_def;
		logic [IDX_W-1:0]   idx;
	} console_req_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [COLOR_W-1:0]   cfg_wdata = COLOR_RESET;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [REQ_W-1:0]     req_type = REQ_PUT;
	logic [CHAR_W-1:0]    char_code = '0;
	logic [COLOR_W-1:0]   char_color = '0;
	logic                 use_default = 1'b0;
	logic [IDX_W-1:0]     cell_index = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [CELL_W-1:0]    cell_value;
	logic [CURSOR_W-1:0]  cursor_cell;
	logic [ROW_OUT_W-1:0] cur_row;
	logic [COL_OUT_W-1:0] cur_col;

	console_req_t pending_reqs[$];
	console_req_t offered_req;
	tcw_result_t  expected_words[$];

	logic [CELL_W-1:0]  screen_model [SCREEN_CELLS];
	int unsigned        row_model;
	int unsigned        col_model;
	int unsigned        cursor_model;
	logic [COLOR_W-1:0] color_model;

	int unsigned sender_gap_pct = 0;
	int unsigned receiver_stall_pct = 0;
	int unsigned holds_asked = 0;
	int unsigned holds_served = 0;
	int unsigned hold_left = 0;
	int unsigned quiet_cycles = 0;
	int unsigned error_count = 0;

	text_console_writer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.char_code(char_code),
		.char_color(char_color),
		.use_default(use_default),
		.cell_index(cell_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cell_value(cell_value),
		.cursor_cell(cursor_cell),
		.cur_row(cur_row),
		.cur_col(cur_col)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic tcw_result_t predict_console(console_req_t r);
		tcw_result_t        res;
		logic [COLOR_W-1:0] attr;
		res = '0;
		case (r.req)
			REQ_PUT: begin
				attr = r.use_def ? color_model : r.color;
				if (row_model >= SCREEN_ROWS) begin
					for (int i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLS; i++)
						screen_model[i] = screen_model[i + SCREEN_COLS];
					for (int i = (SCREEN_ROWS - 1) * SCREEN_COLS; i < SCREEN_CELLS; i++)
						screen_model[i] = {color_model, CHAR_SPACE};
					row_model = SCREEN_ROWS - 1;
				end
				if (r.ch == CHAR_NEWLINE) begin
					col_model = 0;
					row_model++;
				end else begin
					screen_model[row_model * SCREEN_COLS + col_model] = {attr, r.ch};
					col_model++;
					if (col_model >= SCREEN_COLS) begin
						col_model = 0;
						row_model++;
					end
					cursor_model = row_model * SCREEN_COLS + col_model;
				end
			end
			REQ_CLEAR: begin
				for (int i = 0; i < SCREEN_CELLS; i++)
					screen_model[i] = {color_model, CHAR_SPACE};
				cursor_model = 0;
			end
			REQ_READ: begin
				if (r.idx < SCREEN_CELLS)
					res.cell_value = screen_model[r.idx];
			end
			default: ;
		endcase
		res.cursor_cell = cursor_model[CURSOR_W-1:0];
		res.cur_row = row_model[ROW_OUT_W-1:0];
		res.cur_col = col_model[COL_OUT_W-1:0];
		return res;
	endfunction

	task automatic add_req(logic [REQ_W-1:0] req, int unsigned ch,
			int unsigned color, int unsigned use_def, int unsigned idx);
		console_req_t r;
		r.req = req;
		r.ch = CHAR_W'(ch);
		r.color = COLOR_W'(color);
		r.use_def = use_def[0];
		r.idx = IDX_W'(idx);
		pending_reqs.push_back(r);
	endtask

	task automatic queue_random_requests(int unsigned count);
		int unsigned target;
		int unsigned kind;
		int unsigned len;
		int unsigned pick;
		target = pending_reqs.size() + count;
		while (pending_reqs.size() < target) begin
			kind = $urandom_range(99);
			if (kind < 50) begin
				len = ($urandom_range(7) == 0) ? $urandom_range(170, 80) : $urandom_range(20);
				repeat (len)
					add_req(REQ_PUT, $urandom_range(255), $urandom_range(255),
						$urandom_range(1), $urandom_range(2047));
				if ($urandom_range(3) != 0)
					add_req(REQ_PUT, CHAR_NEWLINE, $urandom_range(255),
						$urandom_range(1), $urandom_range(2047));
			end else if (kind < 80) begin
				repeat ($urandom_range(4, 1)) begin
					pick = $urandom_range(99);
					add_req(REQ_READ, $urandom_range(255), $urandom_range(255),
						$urandom_range(1),
						(pick < 60) ? $urandom_range(SCREEN_CELLS - 1) :
						(pick < 85) ? $urandom_range(SCREEN_CELLS - 1,
							SCREEN_CELLS - 2 * SCREEN_COLS) :
						$urandom_range(2047, SCREEN_CELLS));
				end
			end else if (kind < 88) begin
				repeat ($urandom_range(5, 1))
					add_req(REQ_PUT, CHAR_NEWLINE, $urandom_range(255),
						$urandom_range(1), $urandom_range(2047));
			end else if (kind < 97) begin
				add_req(REQ_UNKNOWN, $urandom_range(255), $urandom_range(255),
					$urandom_range(1), $urandom_range(2047));
			end else begin
				add_req(REQ_CLEAR, $urandom_range(255), $urandom_range(255),
					$urandom_range(1), $urandom_range(2047));
			end
		end
	endtask

	task automatic wait_for_idle();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_words.size() != 0);
	endtask

	task automatic check_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			error_count++;
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_words.push_back(predict_console(offered_req));
			if (!in_valid || in_ready) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_gap_pct) begin
					offered_req = pending_reqs.pop_front();
					in_valid <= 1'b1;
					req_type <= offered_req.req;
					char_code <= offered_req.ch;
					char_color <= offered_req.color;
					use_default <= offered_req.use_def;
					cell_index <= offered_req.idx;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin : word_monitor
		tcw_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual %h %0d %0d %0d",
						$time, cell_value, cursor_cell, cur_row, cur_col);
					error_count++;
				end else begin
					want = expected_words.pop_front();
					check_field("cell_value", want.cell_value, cell_value);
					check_field("cursor_cell", want.cursor_cell, cursor_cell);
					check_field("cur_row", want.cur_row, cur_row);
					check_field("cur_col", want.cur_col, cur_col);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (holds_served != holds_asked) begin
				holds_served++;
				hold_left = LONG_HOLD;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		logic [COLOR_W-1:0] phase_color;
		int unsigned        mode;
		for (int i = 0; i < SCREEN_CELLS; i++)
			screen_model[i] = {COLOR_RESET, CHAR_SPACE};
		row_model = 0;
		col_model = 0;
		cursor_model = 0;
		color_model = COLOR_RESET;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset contents, both ends of the store and reads past it
		add_req(REQ_READ, 8'h00, 8'h00, 1'b0, 11'd0);
		add_req(REQ_READ, 8'hFF, 8'hFF, 1'b1, SCREEN_CELLS - 1);
		add_req(REQ_READ, 8'h00, 8'h00, 1'b0, SCREEN_CELLS);
		add_req(REQ_READ, 8'h00, 8'h00, 1'b0, 11'd2047);
		// own color, extreme values, default color
		add_req(REQ_PUT, 8'h41, 8'h00, 1'b0, 11'd0);
		add_req(REQ_PUT, 8'hFF, 8'hFF, 1'b0, 11'd2047);
		add_req(REQ_PUT, 8'h00, 8'h5A, 1'b1, 11'd0);
		add_req(REQ_PUT, CHAR_NEWLINE, 8'hFF, 1'b1, 11'd0);
		add_req(REQ_UNKNOWN, 8'hFF, 8'hFF, 1'b1, 11'd2047);
		add_req(REQ_READ, 8'h00, 8'h00, 1'b0, 11'd0);
		add_req(REQ_READ, 8'h00, 8'h00, 1'b0, 11'd1);
		add_req(REQ_READ, 8'h00, 8'h00, 1'b0, 11'd2);
		add_req(REQ_PUT, 8'h42, 8'h3C, 1'b0, 11'd0);
		add_req(REQ_CLEAR, 8'h00, 8'h00, 1'b0, 11'd0);
		add_req(REQ_READ, 8'h00, 8'h00, 1'b0, 11'd81);
		add_req(REQ_PUT, 8'h43, 8'hC3, 1'b0, 11'd0);
		add_req(REQ_READ, 8'h00, 8'h00, 1'b0, 11'd82);
		add_req(REQ_PUT, CHAR_NEWLINE, 8'h00, 1'b0, 11'd0);
		add_req(REQ_PUT, CHAR_NEWLINE, 8'h00, 1'b0, 11'd0);
		add_req(REQ_READ, 8'h00, 8'h00, 1'b0, 11'd80);
		wait_for_idle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			phase_color = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF :
				(p == 5) ? COLOR_RESET : COLOR_W'($urandom_range(255));
			mode = p % 4;
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_wdata <= phase_color;
			sender_gap_pct <= (mode == 1) ? 83 : (mode == 3) ? 9 : 0;
			receiver_stall_pct <= (mode == 2) ? 83 : (mode == 3) ? 9 : 0;
			if (mode == 0)
				holds_asked <= holds_asked + 1;
			@(posedge clk);
			cfg_we <= 1'b0;
			color_model = phase_color;
			repeat (2) begin
				@(negedge clk);
				queue_random_requests(PHASE_WORDS / 2);
				wait_for_idle();
			end
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
